@@ design/rv32i_alu_register_file_core_assert.svh @@
// ----------------------------------------------------------------------------
// RV32I ALU core assertion macros
// Shared concurrent assertion shorthands for the execute core checkers.
// ----------------------------------------------------------------------------
`ifndef RV32I_ALU_REGISTER_FILE_CORE_ASSERT_SVH
`define RV32I_ALU_REGISTER_FILE_CORE_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define RVALU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define RVALU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define RVALU_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/rvalu_pkg.sv @@
// ----------------------------------------------------------------------------
// RV32I ALU core package
// Operation codes, status codes, field widths and the shared ALU function.
// ----------------------------------------------------------------------------
package rvalu_pkg;

    localparam int NUM_REGS  = 32;
    localparam int XLEN      = 32;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int MODE_W    = 5;
    localparam int STATUS_W  = 3;
    localparam int SHAMT_W   = 5;

    // Input beat layout: mode, dest_reg, src1_reg, src2_reg, immediate.
    localparam int S_FIELDS_W = MODE_W + 3 * REG_IDX_W + XLEN;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    // Result beat layout: status, write_enable, written_value.
    localparam int M_FIELDS_W = STATUS_W + 1 + XLEN;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int M_WE_BIT = STATUS_W;
    localparam int M_VAL_LO = STATUS_W + 1;

    // I-type immediates lie in -2048..2047; biasing by 2048 maps them below 4096.
    localparam logic [XLEN-1:0] IMM_BIAS = XLEN'(2048);
    localparam int IMM_W = 12;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 5'd0,
        MODE_SUB   = 5'd1,
        MODE_SLL   = 5'd2,
        MODE_SLT   = 5'd3,
        MODE_SLTU  = 5'd4,
        MODE_XOR   = 5'd5,
        MODE_SRL   = 5'd6,
        MODE_SRA   = 5'd7,
        MODE_OR    = 5'd8,
        MODE_AND   = 5'd9,
        MODE_ADDI  = 5'd10,
        MODE_SLTI  = 5'd11,
        MODE_SLTIU = 5'd12,
        MODE_XORI  = 5'd13,
        MODE_ORI   = 5'd14,
        MODE_ANDI  = 5'd15,
        MODE_SLLI  = 5'd16,
        MODE_SRLI  = 5'd17,
        MODE_SRAI  = 5'd18,
        MODE_LUI   = 5'd19,
        MODE_HALT  = 5'd20
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_X0      = 3'd1,
        ST_IMM     = 3'd2,
        ST_BADOP   = 3'd3,
        ST_HALT    = 3'd4,
        ST_STOPPED = 3'd5
    } status_t;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [REG_IDX_W-1:0] rd;
        logic [XLEN-1:0]      a;
        logic [XLEN-1:0]      b;
        logic [XLEN-1:0]      imm;
        logic                 stopped;
    } exec_req_t;

    typedef struct packed {
        status_t          status;
        logic             wr_en;
        logic [XLEN-1:0]  value;
        logic             stop;
    } exec_res_t;

    // Register-register operation selected by an R-type code.
    function automatic logic [XLEN-1:0] alu(input mode_t op,
                                            input logic [XLEN-1:0] a,
                                            input logic [XLEN-1:0] b);
        logic [SHAMT_W-1:0] sh;
        begin
            sh = b[SHAMT_W-1:0];
            case (op)
                MODE_ADD:  alu = a + b;
                MODE_SUB:  alu = a - b;
                MODE_SLL:  alu = a << sh;
                MODE_SLT:  alu = XLEN'($signed(a) < $signed(b));
                MODE_SLTU: alu = XLEN'(a < b);
                MODE_XOR:  alu = a ^ b;
                MODE_SRL:  alu = a >> sh;
                MODE_SRA:  alu = $unsigned($signed(a) >>> sh);
                MODE_OR:   alu = a | b;
                default:   alu = a & b;
            endcase
        end
    endfunction

endpackage

@@ design/rv32i_alu_register_file_core.sv @@
// ----------------------------------------------------------------------------
// RV32I integer ALU core with register file
// Executes one decoded RV32I ALU instruction per beat against 32 registers.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  mode, dest_reg, src1_reg, src2_reg, immediate
// m_*       out        m_tvalid/m_tready  status, write_enable, written_value
//
// A beat is registered in the operand stage, where the register file read
// data arrive, and is then executed into the result register, from which its
// result is offered. The operand stage moves whenever the result register is
// empty or drained, so one beat per cycle goes through while the output is not
// stalled; with the output stalled, the input is held off once both are full.
// Reset clears the stop flag and the register valid bits, so registers read zero.
//
module rv32i_alu_register_file_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [4:0] mode, [9:5] dest_reg, [14:10] src1_reg, [19:15] src2_reg,
    // [51:20] immediate, [55:52] zero
    input  logic [rvalu_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] status, [3] write_enable, [35:4] written_value, [39:36] zero
    output logic [rvalu_pkg::M_TDATA_W-1:0] m_tdata
);
    import rvalu_pkg::*;

    localparam int RD_LO   = MODE_W;
    localparam int RS1_LO  = RD_LO + REG_IDX_W;
    localparam int RS2_LO  = RS1_LO + REG_IDX_W;
    localparam int IMM_LO  = RS2_LO + REG_IDX_W;

    // Input side decode of the beat.
    logic                 s_accept;
    logic [REG_IDX_W-1:0] s_rs1;
    logic [REG_IDX_W-1:0] s_rs2;

    // Operand stage.
    logic                 op_valid_reg;
    logic                 op_valid_next;
    logic [MODE_W-1:0]    op_mode_reg;
    logic [REG_IDX_W-1:0] op_rd_reg;
    logic [REG_IDX_W-1:0] op_rs1_reg;
    logic [REG_IDX_W-1:0] op_rs2_reg;
    logic [XLEN-1:0]      op_imm_reg;
    logic                 op_v1_reg;
    logic                 op_v2_reg;
    logic                 op_fire;

    // Register file: data in RAM, a valid bit per register in flops.
    logic [NUM_REGS-1:0]  reg_valid_reg;
    logic [NUM_REGS-1:0]  reg_valid_next;
    logic [XLEN-1:0]      ram_rd1;
    logic [XLEN-1:0]      ram_rd2;

    // Most recent write-back, kept to cover a read issued in the same cycle.
    logic                 lw_en_reg;
    logic [REG_IDX_W-1:0] lw_addr_reg;
    logic [XLEN-1:0]      lw_data_reg;

    logic                 stopped_reg;
    logic                 stopped_next;

    // Result register.
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;

    exec_req_t            req;
    exec_res_t            res;
    logic [XLEN-1:0]      opnd_a;
    logic [XLEN-1:0]      opnd_b;

    assign s_rs1    = s_tdata[RS1_LO +: REG_IDX_W];
    assign s_rs2    = s_tdata[RS2_LO +: REG_IDX_W];
    assign op_fire  = op_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !op_valid_reg || op_fire;
    assign s_accept = s_tvalid && s_tready;

    rvalu_ram #(
        .WIDTH (XLEN),
        .DEPTH (NUM_REGS)
    ) u_regs (
        .aclk     (aclk),
        .wr_en    (op_fire && res.wr_en),
        .wr_addr  (op_rd_reg),
        .wr_data  (res.value),
        .rd0_en   (s_accept),
        .rd0_addr (s_rs1),
        .rd0_data (ram_rd1),
        .rd1_en   (s_accept),
        .rd1_addr (s_rs2),
        .rd1_data (ram_rd2)
    );

    // Operand select: x0 is zero, then the latest write, then the RAM word
    // if that register was ever written since reset.
    always_comb begin
        if (op_rs1_reg == '0) begin
            opnd_a = '0;
        end else if (lw_en_reg && (lw_addr_reg == op_rs1_reg)) begin
            opnd_a = lw_data_reg;
        end else begin
            opnd_a = op_v1_reg ? ram_rd1 : '0;
        end
        if (op_rs2_reg == '0) begin
            opnd_b = '0;
        end else if (lw_en_reg && (lw_addr_reg == op_rs2_reg)) begin
            opnd_b = lw_data_reg;
        end else begin
            opnd_b = op_v2_reg ? ram_rd2 : '0;
        end
    end

    always_comb begin
        req.mode    = op_mode_reg;
        req.rd      = op_rd_reg;
        req.a       = opnd_a;
        req.b       = opnd_b;
        req.imm     = op_imm_reg;
        req.stopped = stopped_reg;
    end

    rvalu_exec u_exec (
        .req (req),
        .res (res)
    );

    always_comb begin
        op_valid_next  = op_valid_reg;
        m_valid_next   = m_valid_reg;
        stopped_next   = stopped_reg;
        reg_valid_next = reg_valid_reg;
        if (op_fire) begin
            op_valid_next = 1'b0;
            m_valid_next  = 1'b1;
            stopped_next  = stopped_reg || res.stop;
            if (res.wr_en) begin
                reg_valid_next[op_rd_reg] = 1'b1;
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept) begin
            op_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            stopped_reg   <= 1'b0;
            reg_valid_reg <= '0;
            lw_en_reg     <= 1'b0;
        end else begin
            op_valid_reg  <= op_valid_next;
            m_valid_reg   <= m_valid_next;
            stopped_reg   <= stopped_next;
            reg_valid_reg <= reg_valid_next;
            if (op_fire) begin
                lw_en_reg <= res.wr_en;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_mode_reg <= s_tdata[MODE_W-1:0];
            op_rd_reg   <= s_tdata[RD_LO +: REG_IDX_W];
            op_rs1_reg  <= s_rs1;
            op_rs2_reg  <= s_rs2;
            op_imm_reg  <= s_tdata[IMM_LO +: XLEN];
            op_v1_reg   <= reg_valid_reg[s_rs1];
            op_v2_reg   <= reg_valid_reg[s_rs2];
        end
        if (op_fire) begin
            lw_addr_reg <= op_rd_reg;
            lw_data_reg <= res.value;
            m_data_reg  <= M_TDATA_W'({res.value, res.wr_en, res.status});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ design/rvalu_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with enables and registered read data.
// ----------------------------------------------------------------------------
module rvalu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd0_en,
    input  logic [$clog2(DEPTH)-1:0] rd0_addr,
    output logic [WIDTH-1:0]         rd0_data,
    input  logic                     rd1_en,
    input  logic [$clog2(DEPTH)-1:0] rd1_addr,
    output logic [WIDTH-1:0]         rd1_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd0_data_reg;
    logic [WIDTH-1:0] rd1_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd0_en) begin
            rd0_data_reg <= mem_reg[rd0_addr];
        end
        if (rd1_en) begin
            rd1_data_reg <= mem_reg[rd1_addr];
        end
    end

    assign rd0_data = rd0_data_reg;
    assign rd1_data = rd1_data_reg;

endmodule

@@ design/rvalu_exec.sv @@
// ----------------------------------------------------------------------------
// RV32I execute logic
// Checks one decoded instruction and computes its status and write-back value.
// ----------------------------------------------------------------------------
module rvalu_exec (
    input  rvalu_pkg::exec_req_t req,
    output rvalu_pkg::exec_res_t res
);
    import rvalu_pkg::*;

    logic            is_reg;
    logic            is_imm;
    logic            is_shift;
    logic            imm_ok;
    logic            shamt_ok;
    logic [XLEN-1:0] biased;
    logic [XLEN-1:0] alu_b;
    logic [XLEN-1:0] result;
    mode_t           op;

    always_comb begin
        is_reg   = req.mode inside {[MODE_ADD:MODE_AND]};
        is_imm   = req.mode inside {[MODE_ADDI:MODE_ANDI]};
        is_shift = req.mode inside {[MODE_SLLI:MODE_SRAI]};
        biased   = req.imm + IMM_BIAS;
        imm_ok   = (biased[XLEN-1:IMM_W] == '0);
        shamt_ok = (req.imm[XLEN-1:SHAMT_W] == '0);
        alu_b    = is_reg ? req.b : req.imm;

        // Immediate forms reuse the register-register datapath.
        case (req.mode)
            MODE_ADDI:  op = MODE_ADD;
            MODE_SLTI:  op = MODE_SLT;
            MODE_SLTIU: op = MODE_SLTU;
            MODE_XORI:  op = MODE_XOR;
            MODE_ORI:   op = MODE_OR;
            MODE_ANDI:  op = MODE_AND;
            MODE_SLLI:  op = MODE_SLL;
            MODE_SRLI:  op = MODE_SRL;
            MODE_SRAI:  op = MODE_SRA;
            default:    op = mode_t'(req.mode);
        endcase

        if (req.mode == MODE_LUI) begin
            result = {req.imm[XLEN-1-IMM_W:0], {IMM_W{1'b0}}};
        end else begin
            result = alu(op, req.a, alu_b);
        end
    end

    always_comb begin
        res.status = ST_OK;
        res.wr_en  = 1'b0;
        res.value  = '0;
        res.stop   = 1'b0;
        if (req.stopped) begin
            res.status = ST_STOPPED;
        end else if (req.mode > MODE_HALT) begin
            res.status = ST_BADOP;
            res.stop   = 1'b1;
        end else if (req.mode == MODE_HALT) begin
            res.status = ST_HALT;
            res.stop   = 1'b1;
        end else if ((is_imm && !imm_ok) || (is_shift && !shamt_ok)) begin
            res.status = ST_IMM;
            res.stop   = 1'b1;
        end else if (req.rd == '0) begin
            res.status = ST_X0;
            res.stop   = 1'b1;
        end else begin
            res.wr_en = 1'b1;
            res.value = result;
        end
    end

endmodule

@@ design/rvalu_checker.sv @@
// ----------------------------------------------------------------------------
// RV32I ALU core port checker
// Watches the top-level ports of the execute core over time.
// ----------------------------------------------------------------------------
`include "rv32i_alu_register_file_core_assert.svh"

module rvalu_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rvalu_pkg::M_TDATA_W-1:0] m_tdata
);
    import rvalu_pkg::*;

    logic            m_we;
    logic            m_ok;
    logic [XLEN-1:0] m_val;

    assign m_we  = m_tdata[M_WE_BIT];
    assign m_ok  = (m_tdata[STATUS_W-1:0] == ST_OK);
    assign m_val = m_tdata[M_VAL_LO +: XLEN];

    // A beat that is held back keeps its payload.
    `RVALU_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result beat changed while stalled")

    // Only a successful instruction writes, and every successful one does.
    `RVALU_ASSERT_IMP(a_we_ok, aclk, aresetn, m_tvalid, m_we == m_ok, "write enable disagrees with status")

    // Nothing written means a zero value.
    `RVALU_ASSERT_IMP(a_val_zero, aclk, aresetn, m_tvalid && !m_we, m_val == '0, "value reported without a write")

    // With the result side free to move, the input always has room.
    `RVALU_ASSERT_IMP(a_ready, aclk, aresetn, !m_tvalid || m_tready, s_tready, "input held off with room for a beat")

    // Reset empties the result register.
    `RVALU_ASSERT_NXT_ALWAYS(a_rst, aclk, !aresetn, !m_tvalid, "result valid right after reset")

endmodule

bind rv32i_alu_register_file_core rvalu_checker u_rvalu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
